// ----- design/ercz_pkg.sv -----
// shared constants and helpers for the encoder rest detector and zero calibrator
package ercz_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int ANGLE_W  = SAMPLE_W + 1;
    localparam int LIMIT_W  = 23;
    localparam int XSQ_W    = 2 * SAMPLE_W;

    // rest-test window
    localparam int WINDOW_SAMPLES = 50;
    localparam int CNT_W          = $clog2(WINDOW_SAMPLES);
    localparam int SUM_W          = 18;
    localparam int SUMSQ_W        = 30;
    localparam int PROD_W         = 2 * SUM_W;
    localparam int NQ_W           = SUMSQ_W + $clog2(WINDOW_SAMPLES + 1);
    localparam int N_SQ           = WINDOW_SAMPLES * WINDOW_SAMPLES;
    localparam int NSQ_W          = $clog2(N_SQ + 1);
    localparam int BOUND_W        = LIMIT_W + NSQ_W;
    localparam int CMP_W          = ((PROD_W > BOUND_W) ? PROD_W : BOUND_W) + 1;

    localparam logic [CNT_W-1:0]   LAST_COUNT = CNT_W'(WINDOW_SAMPLES - 1);
    localparam logic [NSQ_W-1:0]   N_SQ_C     = NSQ_W'(N_SQ);
    localparam logic [NQ_W-1:0]    N_C        = NQ_W'(WINDOW_SAMPLES);
    localparam int                 LIMIT_RESET = 10;
    localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(LIMIT_RESET * N_SQ);

    // angle constants
    localparam logic [SAMPLE_W-1:0] HALF_TURN  = SAMPLE_W'(2048);
    localparam logic [ANGLE_W-1:0]  HALF_ANGLE = {1'b0, HALF_TURN};

    // signed angle of a sample against a zero offset, wrapped to -2047..2048
    function automatic logic [ANGLE_W-1:0] angle_of(
        input logic [SAMPLE_W-1:0] x,
        input logic [SAMPLE_W-1:0] off
    );
        logic [SAMPLE_W-1:0] d;
        d = x - off;
        if (d > HALF_TURN)
        begin
            angle_of = {1'b1, d};
        end
        else
        begin
            angle_of = {1'b0, d};
        end
    endfunction

endpackage

// ----- design/ercz_window_test.sv -----
// exact integer variance test on a closed window: N*sum_sq - sum^2 < limit*N^2
module ercz_window_test (
    input  logic                          clk,
    input  logic                          advance,
    input  logic [ercz_pkg::SUM_W-1:0]    sum,
    input  logic [ercz_pkg::SUMSQ_W-1:0]  sum_sq,
    input  logic [ercz_pkg::BOUND_W-1:0]  bound,
    output logic                          verdict
);
    import ercz_pkg::*;

    logic [PROD_W-1:0] sq_reg;
    logic [NQ_W-1:0]   nq_reg;

    // products of the window totals, one register stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg <= PROD_W'(sum) * PROD_W'(sum);
            nq_reg <= NQ_W'(sum_sq) * N_C;
        end
    end

    // spread is never negative for a full window, so compare sums directly
    assign verdict = CMP_W'(nq_reg) < (CMP_W'(sq_reg) + CMP_W'(bound));

endmodule

// ----- design/encoder_rest_detect_zero_calibrate.sv -----
// top level of the encoder rest detector and zero calibrator
//
// Takes one 12-bit encoder sample per item and returns one result per item: the signed
// angle in counts (4096 per turn) against the captured zero, plus calibration and window
// status. Until calibrated, samples form windows of WINDOW_SAMPLES; a window whose variance
// is below rest_variance_limit makes the following sample the zero reference (its angle
// reads 2048). The block sustains one item per clock cycle in both states while the output
// is not stalled by out_ready; each result passes the input register, window accumulator
// stage, squaring stage and output register. The window verdict is ready as the closing
// sample reaches the squaring stage, and a sample already behind it is corrected on its way out.
// A write to rest_variance_limit is scaled by N*N into the bound register on the same edge.
module encoder_rest_detect_zero_calibrate (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [ercz_pkg::LIMIT_W-1:0]         cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ercz_pkg::SAMPLE_W-1:0]        raw_angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ercz_pkg::ANGLE_W-1:0]  angle_counts,
    output logic                                 is_calibrated,
    output logic                                 window_done,
    output logic                                 window_at_rest
);
    import ercz_pkg::*;

    // configuration
    logic [BOUND_W-1:0]  bound_reg;

    // input stage
    logic                s0_valid_reg;
    logic [SAMPLE_W-1:0] s0_x_reg;
    logic [XSQ_W-1:0]    s0_xsq_reg;

    // calibration and window state
    logic                cal_reg, cal_next;
    logic                cap_reg, cap_next;
    logic [SAMPLE_W-1:0] off_reg, off_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUMSQ_W-1:0]  sumsq_reg, sumsq_next;

    // accumulator stage
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [ANGLE_W-1:0]  s1_angle_reg;
    logic                s1_cal_reg;
    logic                s1_done_reg;
    logic                s1_spec_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [SUMSQ_W-1:0]  s1_sumsq_reg;

    // squaring stage
    logic                s2_valid_reg;
    logic [ANGLE_W-1:0]  s2_angle_reg;
    logic                s2_cal_reg;
    logic                s2_done_reg;
    logic                s2_cap_reg;

    // output register
    logic                out_valid_reg;
    logic [ANGLE_W-1:0]  out_angle_reg;
    logic                out_cal_reg;
    logic                out_done_reg;
    logic                out_rest_reg;

    logic                en;
    logic                commit;
    logic                verdict;
    logic                pass_now;
    logic                take_spec;
    logic                eff_cal;
    logic                eff_cap;
    logic [SAMPLE_W-1:0] eff_off;
    logic                capture;
    logic                accumulate;
    logic                close;
    logic [SUM_W-1:0]    sum_add;
    logic [SUMSQ_W-1:0]  sumsq_add;
    logic [ANGLE_W-1:0]  angle_now;

    // the whole pipeline moves when the output register is free
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = !s0_valid_reg || en;
    assign commit   = en && s0_valid_reg;

    // variance test on the window totals held in the accumulator stage
    ercz_window_test u_window_test (
        .clk     (clk),
        .advance (en),
        .sum     (s1_sum_reg),
        .sum_sq  (s1_sumsq_reg),
        .bound   (bound_reg),
        .verdict (verdict)
    );

    // verdict of a closed window, folded into the state as it leaves the squaring stage
    assign pass_now  = en && s2_valid_reg && s2_done_reg && verdict;
    assign take_spec = pass_now && s1_valid_reg && s1_spec_reg;
    assign eff_cal   = cal_reg || take_spec;
    assign eff_cap   = cap_reg || (pass_now && !(s1_valid_reg && s1_spec_reg));
    assign eff_off   = take_spec ? (s1_x_reg - HALF_TURN) : off_reg;

    // per-item state update
    assign capture    = commit && eff_cap;
    assign accumulate = commit && !eff_cap && !eff_cal;
    assign close      = accumulate && (count_reg == LAST_COUNT);
    assign sum_add    = sum_reg + SUM_W'(s0_x_reg);
    assign sumsq_add  = sumsq_reg + SUMSQ_W'(s0_xsq_reg);

    always_comb
    begin
        cal_next   = eff_cal || capture;
        cap_next   = eff_cap && !capture;
        off_next   = capture ? (s0_x_reg - HALF_TURN) : eff_off;
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        if (accumulate)
        begin
            if (close)
            begin
                count_next = '0;
                sum_next   = '0;
                sumsq_next = '0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_add;
                sumsq_next = sumsq_add;
            end
        end
    end

    assign angle_now = angle_of(s0_x_reg, off_next);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg     <= BOUND_RESET;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_reg       <= 1'b0;
            cap_reg       <= 1'b0;
            off_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                bound_reg <= {{NSQ_W{1'b0}}, cfg_wdata} * {{LIMIT_W{1'b0}}, N_SQ_C};
            end
            if (in_valid && in_ready)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (en)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (en)
            begin
                s1_valid_reg  <= s0_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                cal_reg       <= cal_next;
                cap_reg       <= cap_next;
                off_reg       <= off_next;
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                sumsq_reg     <= sumsq_next;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_x_reg   <= raw_angle;
            s0_xsq_reg <= XSQ_W'(raw_angle) * XSQ_W'(raw_angle);
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg      <= s0_x_reg;
            s1_angle_reg  <= angle_now;
            s1_cal_reg    <= cal_next;
            s1_done_reg   <= close;
            s1_spec_reg   <= s1_valid_reg && s1_done_reg;
            s1_sum_reg    <= sum_add;
            s1_sumsq_reg  <= sumsq_add;

            s2_angle_reg  <= s1_angle_reg;
            s2_cal_reg    <= s1_cal_reg;
            s2_done_reg   <= s1_done_reg;
            s2_cap_reg    <= take_spec;

            // the item behind a passing window becomes the capture item
            out_angle_reg <= s2_cap_reg ? HALF_ANGLE : s2_angle_reg;
            out_cal_reg   <= s2_cal_reg || s2_cap_reg;
            out_done_reg  <= s2_done_reg;
            out_rest_reg  <= s2_done_reg && verdict;
        end
    end

    assign out_valid      = out_valid_reg;
    assign angle_counts   = signed'(out_angle_reg);
    assign is_calibrated  = out_cal_reg;
    assign window_done    = out_done_reg;
    assign window_at_rest = out_rest_reg;

endmodule

// ----- design/ercz_checker.sv -----
// port-level checker for the encoder rest detector and zero calibrator, with its bind
module ercz_port_checks (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [ercz_pkg::ANGLE_W-1:0]  angle_counts,
    input logic                                 is_calibrated,
    input logic                                 window_done,
    input logic                                 window_at_rest
);

    logic cal_seen_reg;
    logic cal_seen_next;

    // remember that a calibrated item has gone out
    assign cal_seen_next = cal_seen_reg || (out_valid && out_ready && is_calibrated);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_seen_reg <= 1'b0;
        end
        else
        begin
            cal_seen_reg <= cal_seen_next;
        end
    end

    // a rest verdict only comes with a closed window
    a_rest_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_at_rest |-> window_done)
        else $error("window_at_rest without window_done");

    // calibration never drops once an item has shown it
    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cal_seen_reg |-> is_calibrated)
        else $error("is_calibrated fell after calibration");

    // no windows close once calibrated
    a_no_window_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_calibrated |-> !window_done)
        else $error("window closed on a calibrated item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_counts)
            && $stable(is_calibrated) && $stable(window_done))
        else $error("result changed while stalled");

endmodule

bind encoder_rest_detect_zero_calibrate ercz_port_checks u_ercz_port_checks (.*);

// ----- tb/ercz_checker.sv -----
// checker for the encoder rest detector: tracks the block, predicts each result and compares
module ercz_checker
    import ercz_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [LIMIT_W-1:0]          cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [SAMPLE_W-1:0]         raw_angle,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [ANGLE_W-1:0]   angle_counts,
    input  logic                        is_calibrated,
    input  logic                        window_done,
    input  logic                        window_at_rest,
    output int                          failures,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      calibrated;
        logic                      done;
        logic                      at_rest;
    } angle_result_t;

    localparam int TURN = 1 << SAMPLE_W;

    // tracked copy of the block state
    logic [LIMIT_W-1:0]  rest_limit;
    logic                locked;
    logic                capture_next;
    logic [SAMPLE_W-1:0] zero_ref;
    int unsigned         window_n;
    logic [17:0]         window_total;
    logic [29:0]         window_total_sq;

    angle_result_t expected_angles[$];
    int            fail_count = 0;

    // next result for one sample, updating the tracked state
    function automatic angle_result_t track_sample(input logic [SAMPLE_W-1:0] x);
        angle_result_t   r;
        longint unsigned spread;
        longint unsigned bound;
        logic [SAMPLE_W-1:0] d;
        int              wrapped;
        r = '0;
        if (capture_next)
        begin
            zero_ref     = x - HALF_TURN;
            locked       = 1'b1;
            capture_next = 1'b0;
        end
        else if (!locked)
        begin
            window_total    = window_total + 18'(x);
            window_total_sq = window_total_sq + 30'(x) * 30'(x);
            window_n++;
            if (window_n >= WINDOW_SAMPLES)
            begin
                // integer variance test: N*sum_sq - sum^2 < limit*N^2
                spread = 64'(WINDOW_SAMPLES) * 64'(window_total_sq)
                         - 64'(window_total) * 64'(window_total);
                bound  = 64'(rest_limit) * 64'(WINDOW_SAMPLES * WINDOW_SAMPLES);
                r.done = 1'b1;
                if (spread < bound)
                begin
                    r.at_rest    = 1'b1;
                    capture_next = 1'b1;
                end
                window_n        = 0;
                window_total    = '0;
                window_total_sq = '0;
            end
        end
        // wrap the difference into -2047..2048
        d       = x - zero_ref;
        wrapped = int'(d);
        if (wrapped > int'(HALF_TURN))
        begin
            wrapped -= TURN;
        end
        r.angle      = ANGLE_W'(wrapped);
        r.calibrated = locked;
        return r;
    endfunction

    // count a failure, report the first ten
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%t mismatch: %s", $realtime, what);
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        angle_result_t want;
        angle_result_t got;
        if (!rst_n)
        begin
            rest_limit      = LIMIT_W'(LIMIT_RESET);
            locked          = 1'b0;
            capture_next    = 1'b0;
            zero_ref        = '0;
            window_n        = 0;
            window_total    = '0;
            window_total_sq = '0;
            expected_angles.delete();
            pending  <= 0;
            failures <= fail_count;
        end
        else
        begin
            if (cfg_wen)
            begin
                rest_limit = cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                got.angle      = angle_counts;
                got.calibrated = is_calibrated;
                got.done       = window_done;
                got.at_rest    = window_at_rest;
                if (expected_angles.size() == 0)
                begin
                    note_failure($sformatf("result with none expected: angle %0d cal %b done %b rest %b",
                                           $signed(got.angle), got.calibrated, got.done,
                                           got.at_rest));
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (got.angle !== want.angle || got.calibrated !== want.calibrated ||
                        got.done !== want.done || got.at_rest !== want.at_rest)
                    begin
                        note_failure($sformatf({"expected angle %0d cal %b done %b rest %b, ",
                                                "got angle %0d cal %b done %b rest %b"},
                                               $signed(want.angle), want.calibrated, want.done,
                                               want.at_rest, $signed(got.angle), got.calibrated,
                                               got.done, got.at_rest));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_angles.push_back(track_sample(raw_angle));
            end
            pending  <= expected_angles.size();
            failures <= fail_count;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// top of the testbench for the encoder rest detector: stimulus, clock, reset and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ercz_pkg::*;

    localparam int RANDOM_TAIL = 190;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_wen   = 1'b0;
    logic [LIMIT_W-1:0]         cfg_wdata = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [SAMPLE_W-1:0]        raw_angle = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [ANGLE_W-1:0]  angle_counts;
    logic                       is_calibrated;
    logic                       window_done;
    logic                       window_at_rest;

    int                         failures;
    int                         backlog;
    int unsigned                burst_left = 0;
    logic [SAMPLE_W-1:0]        zero_pick;

    encoder_rest_detect_zero_calibrate DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_angle      (raw_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .angle_counts   (angle_counts),
        .is_calibrated  (is_calibrated),
        .window_done    (window_done),
        .window_at_rest (window_at_rest)
    );

    ercz_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_angle      (raw_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .angle_counts   (angle_counts),
        .is_calibrated  (is_calibrated),
        .window_done    (window_done),
        .window_at_rest (window_at_rest),
        .failures       (failures),
        .pending        (backlog)
    );

    // clock
    always #5 clk = ~clk;

    // receiver: alternating runs of ready and stall
    logic        rx_level = 1'b0;
    int unsigned rx_run   = 0;
    always @(posedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_level = !rx_level;
            rx_run   = rx_level ? $urandom_range(1, 30) : $urandom_range(1, 6);
        end
        rx_run--;
        out_ready <= rx_level;
    end

    // one sample item, in bursts with random gaps
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        raw_angle <= x;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        in_valid  <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // a window that must fail: two levels in equal halves, or noise touching both ends;
    // the limit is held at or below the window variance, the equal case included
    task automatic send_failing_window(input bit two_level);
        logic [SAMPLE_W-1:0] w[WINDOW_SAMPLES];
        logic [SAMPLE_W-1:0] tmp;
        int unsigned a;
        int unsigned b;
        int unsigned lim_top;
        int unsigned p0;
        int unsigned p1;
        int unsigned j;
        a = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(65, 4095);
        b = $urandom_range(0, 4095 - a);
        if (two_level)
        begin
            lim_top = (a * a) / 4;
            for (int i = 0; i < WINDOW_SAMPLES; i++)
            begin
                w[i] = (i < WINDOW_SAMPLES / 2) ? SAMPLE_W'(b) : SAMPLE_W'(b + a);
            end
            for (int i = WINDOW_SAMPLES - 1; i > 0; i--)
            begin
                j    = $urandom_range(0, i);
                tmp  = w[i];
                w[i] = w[j];
                w[j] = tmp;
            end
        end
        else
        begin
            lim_top = (a * a) / (2 * WINDOW_SAMPLES);
            for (int i = 0; i < WINDOW_SAMPLES; i++)
            begin
                w[i] = SAMPLE_W'($urandom_range(b, b + a));
            end
            p0     = $urandom_range(0, WINDOW_SAMPLES - 1);
            p1     = (p0 + $urandom_range(1, WINDOW_SAMPLES - 1)) % WINDOW_SAMPLES;
            w[p0]  = SAMPLE_W'(b);
            w[p1]  = SAMPLE_W'(b + a);
        end
        settle();
        write_limit(($urandom_range(0, 2) == 0) ? LIMIT_W'(lim_top)
                                                  : LIMIT_W'($urandom_range(0, lim_top)));
        for (int i = 0; i < WINDOW_SAMPLES; i++)
        begin
            send_sample(w[i]);
        end
    endtask

    // stimulus
    initial
    begin
        logic [SAMPLE_W-1:0] edge_samples[$];
        logic [SAMPLE_W-1:0] level;
        edge_samples = '{12'd0, 12'd4095, 12'd2048, 12'd2047, 12'd2049, 12'd1, 12'd4094,
                         12'hAAA, 12'h555, 12'd0, 12'd4095, 12'd2048, 12'd1024, 12'd3072};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first window under the reset limit: field extremes and wrap points, noise to fill
        foreach (edge_samples[i])
        begin
            send_sample(edge_samples[i]);
        end
        for (int i = edge_samples.size(); i < WINDOW_SAMPLES; i++)
        begin
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        end

        // zero variance against a zero limit still fails
        settle();
        write_limit('0);
        level = SAMPLE_W'($urandom_range(0, 4095));
        for (int i = 0; i < WINDOW_SAMPLES; i++)
        begin
            send_sample(level);
        end

        // failing windows over a range of spreads and limits
        for (int k = 0; k < 16; k++)
        begin
            send_failing_window($urandom_range(0, 2) != 0);
        end

        // a limit above the largest possible window variance: any window passes, then the next sample sets the zero
        settle();
        write_limit(LIMIT_W'(4194304));
        for (int i = 0; i < WINDOW_SAMPLES; i++)
        begin
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        end
        zero_pick = SAMPLE_W'($urandom_range(0, 4095));
        send_sample(zero_pick);

        // angles near the capture sample and the new zero: both sides of the half-turn wrap
        send_sample(zero_pick);
        send_sample(zero_pick + 12'd1);
        send_sample(zero_pick - 12'd1);
        send_sample(zero_pick + 12'd2047);
        send_sample(zero_pick + 12'd2048);
        send_sample(12'd0);
        send_sample(12'd4095);

        // calibrated: a limit write must change nothing
        for (int i = 0; i < RANDOM_TAIL; i++)
        begin
            if (i == RANDOM_TAIL / 2)
            begin
                settle();
                write_limit(LIMIT_W'($urandom_range(0, 4194303)));
            end
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        end

        // drain and verdict
        in_valid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
design/ercz_pkg.sv
design/ercz_window_test.sv
design/encoder_rest_detect_zero_calibrate.sv
design/ercz_checker.sv
tb/ercz_checker.sv
tb/testbench.sv
